>>> rtl/core/ptwa_pkg.sv
// Shared types, codes and constants for the peer table with aging.
`timescale 1ns / 1ps
`default_nettype none

package ptwa_pkg;

    localparam int SLOTS_DEFAULT = 4;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

    // Address family codes
    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_REFRESHED = 2'd0;
    localparam logic [1:0] ST_ADDED     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_SWEPT     = 2'd3;

    // Request kinds
    localparam logic ACT_SEEN  = 1'b0;
    localparam logic ACT_SWEEP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  family;
        logic [15:0] port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } peer_key_t;

    typedef struct packed {
        logic hit;
        logic expired;
    } cmp_result_t;

endpackage

`default_nettype wire

>>> rtl/core/ptwa_cmp_unit.sv
// Shared compare unit: key match and age check for one table entry.
`timescale 1ns / 1ps
`default_nettype none

module ptwa_cmp_unit
    import ptwa_pkg::*;
(
    input  wire logic        entry_valid,
    input  wire peer_key_t   entry_key,
    input  wire logic [31:0] entry_seen,
    input  wire peer_key_t   req_key,
    input  wire logic [31:0] now_ms,
    input  wire logic [31:0] age_timeout,
    output cmp_result_t      result
);

    logic        same_port;
    logic        addr_eq;
    logic [31:0] age;

    assign same_port = (entry_key.family == req_key.family) &&
                       (entry_key.port == req_key.port);

    always_comb begin
        unique case (req_key.family)
            FAM_IPV4: addr_eq = (entry_key.addr_low[31:0] == req_key.addr_low[31:0]);
            FAM_IPV6: addr_eq = (entry_key.addr_low == req_key.addr_low) &&
                                (entry_key.addr_high == req_key.addr_high);
            default:  addr_eq = 1'b0;   // other families never match
        endcase
    end

    // age wraps modulo 2^32
    assign age = now_ms - entry_seen;

    assign result.hit     = entry_valid && same_port && addr_eq;
    assign result.expired = entry_valid && (age > age_timeout);

endmodule

`default_nettype wire

>>> rtl/core/ptwa_entry_store.sv
// Entry memory: peer keys and last-seen times, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none

module ptwa_entry_store
    import ptwa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic             aclk,
    input  wire logic [IDX_W-1:0] rd_addr,
    output peer_key_t             rd_key,
    output logic [31:0]           rd_seen,
    input  wire logic             wr_key_en,
    input  wire logic             wr_seen_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire peer_key_t        wr_key,
    input  wire logic [31:0]      wr_seen
);

    peer_key_t   key_mem  [SLOTS];
    logic [31:0] seen_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_seen_en) begin
            seen_mem[wr_addr] <= wr_seen;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key  <= key_mem[rd_addr];
        rd_seen <= seen_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/peer_table_with_aging.sv
// Top level of the peer table with aging: sequencer, valid bits and stream ports.
// A request is taken only in the idle state, so the next one waits until the last one
//   has been scanned and its result written; the single compare unit visits one
//   slot per cycle through the one read port of the entry memory.
// A result may wait on m_tvalid while the next request is taken and scanned.
// Reset (aresetn low, synchronous): all slots invalid, no result pending,
//   age_timeout back to 3000 ms.
`timescale 1ns / 1ps
`default_nettype none

module peer_table_with_aging
    import ptwa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: age_timeout
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata, low to high: now_ms[31:0], addr_family[33:32], peer_port[49:34],
    //   address_high[113:50], address_low[177:114], zero pad[183:178]
    input  wire logic [183:0] s_tdata,
    // tuser: action
    input  wire logic         s_tuser,
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata, low to high: slot_index[1:0], removed_mask[5:2], active_mask[9:6],
    //   zero pad[15:10]
    output logic [15:0]       m_tdata,
    // tuser: status
    output logic [1:0]        m_tuser
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic [31:0]      timeout_reg;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // latched request
    logic             act_reg;
    logic [31:0]      now_reg;
    peer_key_t        key_reg;

    // scan results
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [SLOTS-1:0] removed_reg, removed_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_slot_reg, out_slot_next;
    logic [SLOTS-1:0] out_removed_reg, out_removed_next;
    logic [SLOTS-1:0] out_active_reg, out_active_next;

    // memory and compare unit hookup
    peer_key_t        rd_key;
    logic [31:0]      rd_seen;
    logic             wr_key_en, wr_seen_en;
    logic [IDX_W-1:0] wr_addr;
    cmp_result_t      cmp;
    peer_key_t        in_key;

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign in_key.family    = s_tdata[33:32];
    assign in_key.port      = s_tdata[49:34];
    assign in_key.addr_high = s_tdata[113:50];
    assign in_key.addr_low  = s_tdata[177:114];

    // ------------------------------------------------------------------
    // Entry memory and the shared compare unit
    // The read address runs one slot ahead of idx_reg so the registered
    // read data lines up with the slot under test.
    // ------------------------------------------------------------------
    ptwa_entry_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .aclk       (aclk),
        .rd_addr    (idx_next),
        .rd_key     (rd_key),
        .rd_seen    (rd_seen),
        .wr_key_en  (wr_key_en),
        .wr_seen_en (wr_seen_en),
        .wr_addr    (wr_addr),
        .wr_key     (key_reg),
        .wr_seen    (now_reg)
    );

    ptwa_cmp_unit u_cmp (
        .entry_valid (valid_reg[idx_reg]),
        .entry_key   (rd_key),
        .entry_seen  (rd_seen),
        .req_key     (key_reg),
        .now_ms      (now_reg),
        .age_timeout (timeout_reg),
        .result      (cmp)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_accept) state_next = S_SCAN;
            S_SCAN:  if (idx_reg == LAST_IDX) state_next = S_WRITE;
            S_WRITE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        idx_next         = '0;
        valid_next       = valid_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        removed_next     = removed_reg;
        wr_key_en        = 1'b0;
        wr_seen_en       = 1'b0;
        wr_addr          = hit_idx_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_removed_next = out_removed_reg;
        out_active_next  = out_active_reg;

        unique case (state_reg)
            S_IDLE: begin
                hit_found_next  = 1'b0;
                hit_idx_next    = '0;
                free_found_next = 1'b0;
                free_idx_next   = '0;
                removed_next    = '0;
            end
            S_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (act_reg == ACT_SWEEP) begin
                    if (cmp.expired) begin
                        valid_next[idx_reg]   = 1'b0;
                        removed_next[idx_reg] = 1'b1;
                    end
                end else begin
                    // lowest matching slot wins, likewise the lowest free one
                    if (!hit_found_reg && cmp.hit) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = idx_reg;
                    end
                    if (!free_found_reg && !valid_reg[idx_reg]) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_slot_next    = '0;
                    out_removed_next = '0;
                    if (act_reg == ACT_SWEEP) begin
                        out_status_next  = ST_SWEPT;
                        out_removed_next = removed_reg;
                    end else if (hit_found_reg) begin
                        wr_seen_en      = 1'b1;
                        wr_addr         = hit_idx_reg;
                        out_status_next = ST_REFRESHED;
                        out_slot_next   = hit_idx_reg;
                    end else if (free_found_reg) begin
                        wr_key_en              = 1'b1;
                        wr_seen_en             = 1'b1;
                        wr_addr                = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                        out_status_next        = ST_ADDED;
                        out_slot_next          = free_idx_reg;
                    end else begin
                        out_status_next = ST_FULL;
                    end
                    out_active_next = valid_next;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            timeout_reg    <= TIMEOUT_RESET;
            valid_reg      <= '0;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg <= s_tuser;
            now_reg <= s_tdata[31:0];
            key_reg <= in_key;
        end
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_removed_reg <= out_removed_next;
        out_active_reg  <= out_active_next;
    end

    // ------------------------------------------------------------------
    // Result port: index and masks cut or zero-filled to the field widths
    // ------------------------------------------------------------------
    assign m_tvalid       = out_valid_reg;
    assign m_tuser        = out_status_reg;
    assign m_tdata[15:10] = '0;

    for (genvar j = 0; j < 2; j++) begin : g_slot
        if (j < IDX_W) begin : g_bit
            assign m_tdata[j] = out_slot_reg[j];
        end else begin : g_zero
            assign m_tdata[j] = 1'b0;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_mask
        if (j < SLOTS) begin : g_bit
            assign m_tdata[2 + j] = out_removed_reg[j];
            assign m_tdata[6 + j] = out_active_reg[j];
        end else begin : g_zero
            assign m_tdata[2 + j] = 1'b0;
            assign m_tdata[6 + j] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && idx_reg != LAST_IDX)
            |=> (state_reg == S_SCAN && idx_reg == $past(idx_reg) + 1'b1))
        else $error("scan did not advance to the next slot");

    a_result_from_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_WRITE)
        else $error("result raised outside the write step");

    a_sweep_no_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && act_reg == ACT_SWEEP)
            |=> (valid_reg & ~$past(valid_reg)) == '0)
        else $error("sweep made a slot valid");

    a_removed_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |=> (removed_reg & valid_reg) == '0)
        else $error("freed slot still valid");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the peer table with aging: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import ptwa_pkg::*;

    localparam int SLOTS_N = SLOTS_DEFAULT;
    localparam int POOL_N = 8;              // reusable peer keys per random phase
    localparam int ITEMS_PER_PHASE = 100;   // 7 phases -> about 700 random requests

    // Families with no code in the package: both never match.
    localparam logic [1:0] FAM_OTHER = 2'd2;
    localparam logic [1:0] FAM_RSVD  = 2'd3;

    localparam logic [63:0] ONES64 = '1;
    localparam logic [63:0] MIX_A  = 64'hA5A5_5A5A_0F0F_F0F0;
    localparam logic [63:0] MIX_B  = 64'h5A5A_A5A5_F0F0_0F0F;

    typedef struct packed {
        logic        action;
        logic [31:0] now;
        peer_key_t   key;
    } peer_request_t;

    // Field order matches {m_tuser, slot, removed, active} on the result bus.
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] slot;
        logic [3:0] removed;
        logic [3:0] active;
    } table_result_t;

    // A request on the bus, with a hand-written expectation if fixed_exp is set.
    typedef struct {
        peer_request_t rq;
        logic          fixed_exp;
        table_result_t result;
    } offered_request_t;

    // One row of the directed table.
    typedef struct packed {
        logic        action;
        logic [31:0] now;
        logic [1:0]  family;
        logic [15:0] port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        fixed_exp;
        logic [1:0]  status;
        logic [1:0]  slot;
        logic [3:0]  removed;
        logic [3:0]  active;
    } dir_row_t;

    // Directed rows run with the reset timeout of 3000 ms. Rows with fixed_exp = 0
    // take their expectation from the table predictor.
    dir_row_t directed_rows [20] = '{
        // sweep of an empty table
        '{ACT_SWEEP, 32'd0, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b1, ST_SWEPT, 2'd0, 4'b0000, 4'b0000},
        // first peer lands in slot 0
        '{ACT_SEEN, 32'd0, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b1, ST_ADDED, 2'd0, 4'b0000, 4'b0001},
        // IPv4: upper address bits are don't-care, so this refreshes slot 0
        '{ACT_SEEN, 32'd5, FAM_IPV4, 16'h0000, ONES64, 64'hFFFF_FFFF_0000_0000,
          1'b1, ST_REFRESHED, 2'd0, 4'b0000, 4'b0001},
        // all-ones IPv6 peer at the top of the time range
        '{ACT_SEEN, 32'hFFFF_FFFF, FAM_IPV6, 16'hFFFF, ONES64, ONES64,
          1'b1, ST_ADDED, 2'd1, 4'b0000, 4'b0011},
        // IPv6 differing in the top address bit is a new peer
        '{ACT_SEEN, 32'd3005, FAM_IPV6, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFF, ONES64,
          1'b1, ST_ADDED, 2'd2, 4'b0000, 4'b0111},
        // other family is stored like any new key
        '{ACT_SEEN, 32'd0, FAM_OTHER, 16'h8000, MIX_A, MIX_B,
          1'b1, ST_ADDED, 2'd3, 4'b0000, 4'b1111},
        // ...but never matches, so the same key again finds the table full
        '{ACT_SEEN, 32'd1, FAM_OTHER, 16'h8000, MIX_A, MIX_B,
          1'b1, ST_FULL, 2'd0, 4'b0000, 4'b1111},
        '{ACT_SEEN, 32'd2, FAM_RSVD, 16'h0001, 64'd0, 64'd1,
          1'b1, ST_FULL, 2'd0, 4'b0000, 4'b1111},
        '{ACT_SEEN, 32'hFFFF_FFFF, FAM_IPV4, 16'h0000, 64'd0, 64'h0000_0000_8000_0000,
          1'b1, ST_FULL, 2'd0, 4'b0000, 4'b1111},
        '{ACT_SEEN, 32'hFFFF_FFFF, FAM_IPV6, 16'hFFFF, ONES64, ONES64,
          1'b1, ST_REFRESHED, 2'd1, 4'b0000, 4'b1111},
        // age exactly at the timeout, wrapped age, zero age and a plain expiry
        '{ACT_SWEEP, 32'd3005, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b0, ST_SWEPT, 2'd0, 4'b0000, 4'b0000},
        '{ACT_SEEN, 32'd3006, FAM_IPV4, 16'h1234, 64'd0, 64'h0000_0000_C0A8_0001,
          1'b0, ST_ADDED, 2'd0, 4'b0000, 4'b0000},
        // same address, other port
        '{ACT_SEEN, 32'd3006, FAM_IPV4, 16'h1235, 64'd0, 64'h0000_0000_C0A8_0001,
          1'b0, ST_ADDED, 2'd0, 4'b0000, 4'b0000},
        // same port, address off in bit 31
        '{ACT_SEEN, 32'd3007, FAM_IPV4, 16'h1234, 64'd0, 64'h0000_0000_40A8_0001,
          1'b0, ST_ADDED, 2'd0, 4'b0000, 4'b0000},
        '{ACT_SWEEP, 32'd6005, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b0, ST_SWEPT, 2'd0, 4'b0000, 4'b0000},
        '{ACT_SWEEP, 32'h8000_0000, FAM_IPV6, 16'hFFFF, ONES64, ONES64,
          1'b0, ST_SWEPT, 2'd0, 4'b0000, 4'b0000},
        '{ACT_SWEEP, 32'h8000_0000, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b1, ST_SWEPT, 2'd0, 4'b0000, 4'b0000},
        // same zero key under two families: no cross match
        '{ACT_SEEN, 32'h8000_0000, FAM_IPV6, 16'h0000, 64'd0, 64'd0,
          1'b1, ST_ADDED, 2'd0, 4'b0000, 4'b0001},
        '{ACT_SEEN, 32'h8000_0000, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b1, ST_ADDED, 2'd1, 4'b0000, 4'b0011},
        '{ACT_SWEEP, 32'h8000_0BB9, FAM_IPV4, 16'h0000, 64'd0, 64'd0,
          1'b0, ST_SWEPT, 2'd0, 4'b0000, 4'b0000}
    };

    // ------------------------------------------------------------------
    // DUT hookup. All inputs start at known values.
    // ------------------------------------------------------------------
    logic         aclk;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata     = '0;   // now, family, port, addr_high, addr_low, pad
    logic         s_tuser     = 1'b0; // action
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [15:0]  m_tdata;            // slot, removed_mask, active_mask, pad
    logic [1:0]   m_tuser;            // status

    peer_table_with_aging #(
        .SLOTS(SLOTS_N)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop.
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirror of the peer table and the timeout register.
    // ------------------------------------------------------------------
    logic        tbl_valid [SLOTS_N] = '{default: 1'b0};
    peer_key_t   tbl_key   [SLOTS_N] = '{default: '0};
    logic [31:0] tbl_seen  [SLOTS_N] = '{default: '0};
    logic [31:0] cur_timeout = TIMEOUT_RESET;

    offered_request_t offered_requests [$];  // driven, not yet accepted
    table_result_t    pending_results  [$];  // accepted, result not yet seen

    int          fault_count = 0;
    int          send_burst_left = 0;        // requests left in a no-gap stretch
    logic [31:0] sim_now = '0;               // running millisecond clock for random phases
    peer_key_t   key_pool [POOL_N];

    task automatic flag_failure(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Mostly short idles, now and then a long one.
    function automatic int idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the mirrored table and return the expected result.
    function automatic table_result_t update_peer_table(input peer_request_t rq);
        table_result_t res;
        int            hit;
        int            free_idx;
        logic [31:0]   age;
        logic          same_key;
        res = '0;
        hit = -1;
        free_idx = -1;
        if (rq.action == ACT_SWEEP) begin
            for (int i = 0; i < SLOTS_N; i++) begin
                // age wraps mod 2^32; an entry seen this millisecond is age 0
                age = rq.now - tbl_seen[i];
                if (tbl_valid[i] && age > cur_timeout) begin
                    tbl_valid[i] = 1'b0;
                    res.removed[i] = 1'b1;
                end
            end
            res.status = ST_SWEPT;
        end else begin
            for (int i = 0; i < SLOTS_N; i++) begin
                // IPv4 compares port + low 32 address bits, IPv6 port + all 128;
                // any other family never matches
                same_key = tbl_valid[i]
                    && tbl_key[i].family == rq.key.family
                    && tbl_key[i].port == rq.key.port
                    && ((rq.key.family == FAM_IPV4
                         && tbl_key[i].addr_low[31:0] == rq.key.addr_low[31:0])
                     || (rq.key.family == FAM_IPV6
                         && tbl_key[i].addr_high == rq.key.addr_high
                         && tbl_key[i].addr_low == rq.key.addr_low));
                if (hit < 0 && same_key)
                    hit = i;
                if (free_idx < 0 && !tbl_valid[i])
                    free_idx = i;
            end
            if (hit >= 0) begin
                tbl_seen[hit] = rq.now;
                res.status = ST_REFRESHED;
                res.slot = 2'(hit);
            end else if (free_idx >= 0) begin
                tbl_valid[free_idx] = 1'b1;
                tbl_key[free_idx] = rq.key;
                tbl_seen[free_idx] = rq.now;
                res.status = ST_ADDED;
                res.slot = 2'(free_idx);
            end else begin
                res.status = ST_FULL;
            end
        end
        for (int i = 0; i < SLOTS_N; i++)
            res.active[i] = tbl_valid[i];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Bus watcher. Result check runs before the request accept so that the
    // outcome never hangs on process order within one edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : bus_watch
        table_result_t    got;
        table_result_t    want;
        offered_request_t ofr;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[1:0], m_tdata[5:2], m_tdata[9:6]};
                if (pending_results.size() == 0) begin
                    flag_failure($sformatf("unexpected result: status %0d slot %0d rm %b act %b",
                        got.status, got.slot, got.removed, got.active));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        flag_failure($sformatf(
                            "mismatch: exp status %0d slot %0d rm %b act %b, %s",
                            want.status, want.slot, want.removed, want.active,
                            $sformatf("got status %0d slot %0d rm %b act %b",
                                got.status, got.slot, got.removed, got.active)));
                end
            end
            if (s_tvalid && s_tready) begin
                ofr = offered_requests.pop_front();
                want = update_peer_table(ofr.rq);
                pending_results.push_back(ofr.fixed_exp ? ofr.result : want);
            end
        end
    end

    // Result side back-pressure: ready runs of random length, sometimes long
    // stretches with no stall at all.
    initial begin : result_sink
        int run_len;
        int stall_len;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 6);
            repeat (run_len) @(posedge aclk);
            stall_len = idle_length();
            if (stall_len > 0) begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // Put one request on the bus, hold it until taken, then maybe idle.
    // Valid stays high between back-to-back requests.
    task automatic send_request(input peer_request_t rq, input logic fixed_exp,
                                input table_result_t fixed_res);
        int gap;
        offered_requests.push_back('{rq: rq, fixed_exp: fixed_exp, result: fixed_res});
        s_tvalid <= 1'b1;
        s_tuser  <= rq.action;
        s_tdata  <= {6'd0, rq.key.addr_low, rq.key.addr_high, rq.key.port,
                     rq.key.family, rq.now};
        do @(posedge aclk); while (!s_tready);
        if (send_burst_left > 0) begin
            send_burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0)
                send_burst_left = $urandom_range(20, 60);
            gap = idle_length();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every accepted request has its result,
    // plus the pipeline latency so the block is truly idle.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (offered_requests.size() + pending_results.size() != 0)
            @(posedge aclk);
        repeat (SLOTS_N + 4) @(posedge aclk);
    endtask

    task automatic write_age_timeout(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_timeout = value;
    endtask

    function automatic peer_key_t random_key(input logic [1:0] family);
        peer_key_t k;
        k.family    = family;
        k.port      = 16'($urandom);
        k.addr_high = {$urandom, $urandom};
        k.addr_low  = {$urandom, $urandom};
        return k;
    endfunction

    // Mostly well-formed traffic from the key pool against a running clock;
    // the rest is fresh keys and fully random noise.
    function automatic peer_request_t next_random_request();
        peer_request_t rq;
        int unsigned   roll;
        int unsigned   pick;
        int unsigned   bit_idx;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            // same millisecond: zero age
        end else if (roll < 70) begin
            sim_now += 32'($urandom_range(1, 4));
        end else if (roll < 85) begin
            // step right around the timeout boundary
            sim_now += cur_timeout - 32'd2 + 32'($urandom_range(0, 4));
        end else if (roll < 95) begin
            sim_now += 32'($urandom_range(5, 1000));
        end else begin
            sim_now = $urandom;
        end

        rq.action = ACT_SEEN;
        rq.now = sim_now;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            rq.action = ACT_SWEEP;
            rq.key = random_key(2'($urandom_range(0, 3)));
        end else if (roll < 85) begin
            rq.key = key_pool[$urandom_range(0, POOL_N - 1)];
            // IPv4 ignores these bits, so scramble them on every reuse
            if (rq.key.family == FAM_IPV4) begin
                rq.key.addr_high = {$urandom, $urandom};
                rq.key.addr_low[63:32] = $urandom;
            end
            if ($urandom_range(0, 9) == 0) begin
                // near miss: one bit off
                pick = $urandom_range(0, 2);
                bit_idx = $urandom_range(0, 63);
                if (pick == 0)
                    rq.key.port[bit_idx % 16] = ~rq.key.port[bit_idx % 16];
                else if (pick == 1)
                    rq.key.addr_low[bit_idx % 32] = ~rq.key.addr_low[bit_idx % 32];
                else
                    rq.key.addr_high[bit_idx] = ~rq.key.addr_high[bit_idx];
            end
        end else if (roll < 95) begin
            rq.key = random_key(2'($urandom_range(0, 3)));
        end else begin
            rq.action = 1'($urandom_range(0, 1));
            rq.now = $urandom;
            rq.key = random_key(2'($urandom_range(0, 3)));
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases at several
    // timeouts including both extremes.
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t      row;
        peer_request_t rq;
        table_result_t fixed_res;
        logic [31:0]   phase_timeouts [7];
        logic [31:0]   phase_start [7];

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            rq.action        = row.action;
            rq.now           = row.now;
            rq.key.family    = row.family;
            rq.key.port      = row.port;
            rq.key.addr_high = row.addr_high;
            rq.key.addr_low  = row.addr_low;
            fixed_res = {row.status, row.slot, row.removed, row.active};
            send_request(rq, row.fixed_exp, fixed_res);
        end

        phase_timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd1, TIMEOUT_RESET,
                           32'($urandom_range(2, 50)), 32'h8000_0000, $urandom};
        // two phases start just below the wrap point of the ms counter
        phase_start = '{$urandom, $urandom, 32'hFFFF_FFF0, $urandom,
                        $urandom, $urandom, 32'hFFFF_F000};

        foreach (phase_timeouts[p]) begin
            drain_requests();
            write_age_timeout(phase_timeouts[p]);
            sim_now = phase_start[p];
            for (int k = 0; k < POOL_N; k++)
                key_pool[k] = random_key((k == POOL_N - 1)
                    ? 2'($urandom_range(2, 3)) : ((k % 2 == 1) ? FAM_IPV6 : FAM_IPV4));
            // same port and address under the other family
            key_pool[3] = key_pool[2];
            key_pool[3].family = FAM_IPV6;
            repeat (ITEMS_PER_PHASE)
                send_request(next_random_request(), 1'b0, '0);
        end

        drain_requests();
        if (fault_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> peer_table_with_aging.f
rtl/core/ptwa_pkg.sv
rtl/core/ptwa_cmp_unit.sv
rtl/core/ptwa_entry_store.sv
rtl/core/peer_table_with_aging.sv
verif/tb_top.sv
